// File: sv/pdct_pkg.sv
// package for the poisson disk candidate test block
// types, sizes and status codes; no dependencies
package pdct_pkg;
    localparam int MAX_GRID_W  = 64;
    localparam int COORD_BITS  = 20;
    localparam int CELL_BITS   = $clog2(MAX_GRID_W);
    localparam int MAP_DEPTH   = MAX_GRID_W * MAX_GRID_W;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;
    localparam int CNT_W       = STORE_AW + 1;
    localparam int GW_W        = 7;

    // neighbor walk: 0..8 cover the 3x3 block, the home cell check comes first
    localparam logic [3:0] NB_LAST = 4'd8;
    localparam logic [3:0] NB_HOME = 4'd9;

    typedef enum logic [2:0] {
        ST_ACCEPT   = 3'd0,
        ST_OUTSIDE  = 3'd1,
        ST_OCCUPIED = 3'd2,
        ST_CLOSE    = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_AREA = 2'd0,
        REG_MIND = 2'd1,
        REG_INV  = 2'd2,
        REG_GW   = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CELL, S_NADDR, S_NMAP, S_NSTORE, S_NSQ, S_NSUM,
        S_INSERT, S_CLEAR, S_OUT, S_INIT
    } t_state;
endpackage

// File: sv/poisson_disk_candidate_test.sv
// poisson disk candidate test: grid cell occupancy and 3x3 neighbor distance check, then
// insert of accepted candidates; i_func instead clears the cell map and the sample count.
// Outside/off-grid ends at the cell step, occupied home cell at its map read, else 3x3 walk
// throughput: one item at a time, next input accepted in the cycle after the result is registered,
// later if the previous result has not been taken yet
// synchronous active-low reset clears control, loads config defaults, then clears all 4096 map entries
module poisson_disk_candidate_test import pdct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [39:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_status,
    output logic [11:0]           o_sample_index,
    output logic [5:0]            o_cell_x,
    output logic [5:0]            o_cell_y
);
    localparam int PW = COORD_BITS + 16;
    localparam int CW = PW - 24;

    logic [19:0] r_area;
    logic [39:0] r_mind;
    logic [15:0] r_inv;
    logic [GW_W-1:0] r_gw;

    logic [STORE_AW:0] cell_map [MAP_DEPTH];
    logic [2*COORD_BITS-1:0] store [STORE_DEPTH];

    t_state r_state, n_state;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [PW-1:0] r_px, r_py;
    logic [CELL_BITS:0] r_w;
    logic [CW-1:0] r_cx, r_cy;
    logic [3:0] r_nb;
    logic [MAP_AW-1:0] r_maddr;
    logic [STORE_AW:0] r_mrd;
    logic [2*COORD_BITS-1:0] r_srd;
    logic [63:0] r_sqx, r_sqy;
    logic [CNT_W-1:0] r_count;
    logic [MAP_AW-1:0] r_clr;
    t_status r_wst, n_wst;
    logic [STORE_AW-1:0] r_widx;
    logic [5:0] r_wcx, r_wcy;
    logic r_nvalid;
    t_status r_status;
    logic [STORE_AW-1:0] r_sidx;
    logic [5:0] r_ocx, r_ocy;

    logic map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [STORE_AW:0] map_wdata;
    logic [MAP_AW-1:0] map_raddr;
    logic store_we;

    // effective width
    logic [CELL_BITS:0] eff_w;
    always_comb begin
        if (r_gw == '0) eff_w = (CELL_BITS+1)'(1);
        else if (r_gw > GW_W'(MAX_GRID_W)) eff_w = (CELL_BITS+1)'(MAX_GRID_W);
        else eff_w = (CELL_BITS+1)'(r_gw);
    end

    // neighbor offsets, x in the upper pair and y in the lower pair
    logic [3:0] nb_off;
    always_comb begin
        case (r_nb)
            4'd0: nb_off = 4'b00_00;
            4'd1: nb_off = 4'b00_01;
            4'd2: nb_off = 4'b00_10;
            4'd3: nb_off = 4'b01_00;
            4'd4: nb_off = 4'b01_01;
            4'd5: nb_off = 4'b01_10;
            4'd6: nb_off = 4'b10_00;
            4'd7: nb_off = 4'b10_01;
            4'd8: nb_off = 4'b10_10;
            default: nb_off = 4'b01_01;
        endcase
    end

    // neighbor coordinates
    logic signed [CW+1:0] nx, ny, w_s;
    logic n_in;
    assign w_s = $signed({1'b0, (CW+1)'(r_w)});
    always_comb begin
        nx = $signed({2'b0, r_cx}) + $signed({{CW{1'b0}}, nb_off[3:2]})
            - $signed((CW+2)'(1));
        ny = $signed({2'b0, r_cy}) + $signed({{CW{1'b0}}, nb_off[1:0]})
            - $signed((CW+2)'(1));
        n_in = !nx[CW+1] && !ny[CW+1] && nx < w_s && ny < w_s;
    end

    logic [MAP_AW-1:0] home_addr, nb_addr;
    assign home_addr = MAP_AW'(r_cx[CELL_BITS-1:0] * r_w + r_cy[CELL_BITS-1:0]);
    assign nb_addr = MAP_AW'(nx[CELL_BITS-1:0] * r_w + ny[CELL_BITS-1:0]);

    logic [CW-1:0] px_cell, py_cell;
    logic outside, off_grid, store_full;
    assign px_cell = r_px[PW-1:24];
    assign py_cell = r_py[PW-1:24];
    assign outside = r_x > r_area || r_y > r_area;
    assign off_grid = px_cell >= CW'(r_w) || py_cell >= CW'(r_w);
    assign store_full = r_count[STORE_AW];

    logic [COORD_BITS-1:0] sx, sy, dxv, dyv;
    assign sx = r_srd[2*COORD_BITS-1:COORD_BITS];
    assign sy = r_srd[COORD_BITS-1:0];
    assign dxv = (sx > r_x) ? sx - r_x : r_x - sx;
    assign dyv = (sy > r_y) ? sy - r_y : r_y - sy;

    logic [64:0] dsum;
    logic [63:0] dsat;
    logic too_close;
    assign dsum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign dsat = dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
    assign too_close = dsat < {24'd0, r_mind};

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= 20'd51200;
            r_mind <= 40'd6553600;
            r_inv  <= 16'd1810;
            r_gw   <= GW_W'(64);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_AREA: r_area <= i_cfg_data[19:0];
                REG_MIND: r_mind <= i_cfg_data;
                REG_INV:  r_inv  <= i_cfg_data[15:0];
                REG_GW:   r_gw   <= i_cfg_data[GW_W-1:0];
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (map_we) cell_map[map_waddr] <= map_wdata;
        r_mrd <= cell_map[map_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (store_we) store[r_count[STORE_AW-1:0]] <= {r_x, r_y};
        r_srd <= store[r_mrd[STORE_AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_wst = r_wst;
        o_ready = 1'b0;
        map_we = 1'b0;
        map_waddr = r_clr;
        map_wdata = '0;
        map_raddr = r_maddr;
        store_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = i_func ? S_CLEAR : S_MUL;
                    n_wst = i_func ? ST_CLEARED : ST_ACCEPT;
                end
            end
            S_MUL: n_state = S_CELL;
            S_CELL: begin
                if (outside || off_grid) begin
                    n_state = S_OUT;
                    n_wst = ST_OUTSIDE;
                end else begin
                    n_state = S_NADDR;
                end
            end
            S_NADDR: begin
                map_raddr = nb_addr;
                if (r_nb == NB_HOME || n_in) begin
                    n_state = S_NMAP;
                end else if (r_nb == NB_LAST) begin
                    n_state = store_full ? S_OUT : S_INSERT;
                    n_wst = store_full ? ST_FULL : ST_ACCEPT;
                end
            end
            S_NMAP: n_state = S_NSTORE;
            S_NSTORE: begin
                if (r_mrd[STORE_AW]) begin
                    if (r_nb == NB_HOME) begin
                        n_state = S_OUT;
                        n_wst = ST_OCCUPIED;
                    end else begin
                        n_state = S_NSQ;
                    end
                end else if (r_nb == NB_LAST) begin
                    n_state = store_full ? S_OUT : S_INSERT;
                    n_wst = store_full ? ST_FULL : ST_ACCEPT;
                end else begin
                    n_state = S_NADDR;
                end
            end
            S_NSQ: n_state = S_NSUM;
            S_NSUM: begin
                if (too_close) begin
                    n_state = S_OUT;
                    n_wst = ST_CLOSE;
                end else if (r_nb == NB_LAST) begin
                    n_state = store_full ? S_OUT : S_INSERT;
                    n_wst = store_full ? ST_FULL : ST_ACCEPT;
                end else begin
                    n_state = S_NADDR;
                end
            end
            S_INSERT: begin
                store_we = 1'b1;
                map_we = 1'b1;
                map_waddr = home_addr;
                map_wdata = {1'b1, r_count[STORE_AW-1:0]};
                n_state = S_OUT;
            end
            S_CLEAR: begin
                map_we = 1'b1;
                if (r_clr == MAP_AW'(MAP_DEPTH - 1)) n_state = S_OUT;
            end
            S_INIT: begin
                map_we = 1'b1;
                if (r_clr == MAP_AW'(MAP_DEPTH - 1)) n_state = S_IDLE;
            end
            S_OUT: begin
                if (!r_nvalid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_wst <= ST_ACCEPT;
            r_clr <= '0;
            r_count <= '0;
            r_nvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wst <= n_wst;
            if (r_state == S_OUT && n_state == S_IDLE) r_nvalid <= 1'b1;
            else if (i_ready) r_nvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_clr <= '0;
                    if (i_valid) begin
                        r_x <= i_cand_x;
                        r_y <= i_cand_y;
                        r_w <= eff_w;
                        r_widx <= '0;
                        r_wcx <= '0;
                        r_wcy <= '0;
                        if (i_func) r_count <= '0;
                    end
                end
                S_MUL: begin
                    r_px <= PW'(r_x * r_inv);
                    r_py <= PW'(r_y * r_inv);
                end
                S_CELL: begin
                    r_cx <= px_cell;
                    r_cy <= py_cell;
                    r_nb <= NB_HOME;
                    if (outside) begin
                        r_wcx <= '0;
                        r_wcy <= '0;
                    end else begin
                        r_wcx <= (px_cell > CW'(63)) ? 6'd63 : px_cell[5:0];
                        r_wcy <= (py_cell > CW'(63)) ? 6'd63 : py_cell[5:0];
                    end
                end
                S_NADDR: begin
                    r_maddr <= map_raddr;
                    if (r_nb != NB_HOME && !n_in) r_nb <= r_nb + 4'd1;
                end
                S_NMAP: ;
                S_NSTORE: begin
                    if (!r_mrd[STORE_AW]) r_nb <= (r_nb == NB_HOME) ? 4'd0 : r_nb + 4'd1;
                end
                S_NSQ: begin
                    r_sqx <= 64'(dxv * dxv);
                    r_sqy <= 64'(dyv * dyv);
                end
                S_NSUM: r_nb <= r_nb + 4'd1;
                S_INSERT: begin
                    r_widx <= r_count[STORE_AW-1:0];
                    r_count <= r_count + CNT_W'(1);
                end
                S_CLEAR: r_clr <= r_clr + MAP_AW'(1);
                S_INIT: r_clr <= r_clr + MAP_AW'(1);
                S_OUT: begin
                    if (n_state == S_IDLE) begin
                        r_status <= r_wst;
                        r_sidx <= r_widx;
                        r_ocx <= r_wcx;
                        r_ocy <= r_wcy;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_nvalid;
    assign o_status = r_status;
    assign o_sample_index = r_sidx;
    assign o_cell_x = r_ocx;
    assign o_cell_y = r_ocy;
endmodule
